[hw/rtl/spsd_pkg.sv]
// Package for the strided prefix sum / difference block.
// Holds field widths, payload types, reset values and register indexes.
// Depends on nothing; the interfaces, the top level and the checker import it.
`default_nettype none

package spsd_pkg;

  localparam int COEFF_W    = 62;
  localparam int MOD_W      = 63;
  localparam int PRIME_W    = 12;
  localparam int STRIDE_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  typedef logic [COEFF_W-1:0]    coeff_t;
  typedef logic [MOD_W-1:0]      mod_t;
  typedef logic [PRIME_W-1:0]    rows_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS      = 2'd0,
    REG_INVERSE_MODE = 2'd1,
    REG_PRIME        = 2'd2,
    REG_STRIDE       = 2'd3
  } cfg_reg_t;

  localparam mod_t  MOD_MIN    = 63'd2;
  localparam mod_t  MOD_MAX    = 63'h4000_0000_0000_0000;
  localparam rows_t PRIME_MIN  = 12'd3;
  localparam rows_t ROWS_RESET = 12'd2;

endpackage

`default_nettype wire

[hw/rtl/spsd_if.sv]
// Channel interfaces of the strided prefix sum / difference block.
// Coefficient input, result output and configuration write channels.
// Depends on spsd_pkg for the payload types.
`default_nettype none

interface spsd_coeff_if;
  import spsd_pkg::*;

  logic   valid;
  logic   ready;
  coeff_t coeff_in;

  modport source (output valid, output coeff_in, input ready);
  modport sink (input valid, input coeff_in, output ready);
endinterface

interface spsd_result_if;
  import spsd_pkg::*;

  logic   valid;
  logic   ready;
  coeff_t coeff_out;
  logic   bad_input;

  modport source (output valid, output coeff_out, output bad_input, input ready);
  modport sink (input valid, input coeff_out, input bad_input, output ready);
endinterface

interface spsd_cfg_if;
  import spsd_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/spsd_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// Depends on nothing.
`default_nettype none

module spsd_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic                                         rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/strided_prefix_sum_difference.sv]
// Top level of the strided prefix sum / difference block.
// Depends on spsd_pkg, the channel interfaces in spsd_if and spsd_ram.
//
// Coefficients arrive on the coeffs channel in memory order of blocks of
// prime-1 rows of stride columns. Each transfer yields exactly one transfer on
// the results channel: the coefficient reduced below the modulus, turned into
// a running column sum (forward) or a row difference (inverse), plus a flag
// for an input that was not below the modulus.
// Configuration writes arrive on the cfg channel, which is always ready, and
// take effect for the next coefficient. The user must make them while no
// coefficient is in flight; the block itself does not enforce it.
// A result passes the stage 1, stage 2 and output registers after its coefficient
// is taken, and one coefficient is taken every cycle while the receiver is ready.
// The rate is set by the column store: one read when a coefficient enters, one
// write as it leaves stage 2, and a forwarded write value when it shares a column with one not yet written.
// Reset clears the pipeline, the row and column position and the registers;
// the column store keeps its contents and needs no clearing pass.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps taking coefficients until its three stages are full.
`default_nettype none

module strided_prefix_sum_difference #(
  parameter int MAX_STRIDE = 1024
) (
  input  logic          clk,
  input  logic          rst,
  spsd_coeff_if.sink    coeffs,
  spsd_result_if.source results,
  spsd_cfg_if.sink      cfg
);

  import spsd_pkg::*;

  localparam int CW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int SW = $clog2(MAX_STRIDE + 1);
  localparam logic [SW-1:0] COLS_MAX = SW'(MAX_STRIDE);

  // Configuration, held in its clamped form.
  mod_t          q;
  logic          inv;
  rows_t         rows;
  logic [SW-1:0] cols;

  mod_t          cfg_q;
  rows_t         cfg_rows;
  logic [SW-1:0] cfg_cols;
  rows_t         cfg_prime;
  logic [31:0]   cfg_stride;

  always_comb begin
    cfg_prime  = cfg.data[PRIME_W-1:0];
    cfg_stride = 32'(cfg.data[STRIDE_W-1:0]);
    if (cfg.data < MOD_MIN) begin
      cfg_q = MOD_MIN;
    end else if (cfg.data > MOD_MAX) begin
      cfg_q = MOD_MAX;
    end else begin
      cfg_q = cfg.data;
    end
    if (cfg_prime < PRIME_MIN) begin
      cfg_rows = rows_t'(1);
    end else begin
      cfg_rows = cfg_prime - rows_t'(1);
    end
    if (cfg_stride == 32'd0) begin
      cfg_cols = SW'(1);
    end else if (cfg_stride > 32'(MAX_STRIDE)) begin
      cfg_cols = COLS_MAX;
    end else begin
      cfg_cols = cfg_stride[SW-1:0];
    end
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q    <= MOD_MIN;
      inv  <= 1'b0;
      rows <= ROWS_RESET;
      cols <= SW'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MODULUS:      q    <= cfg_q;
        REG_INVERSE_MODE: inv  <= cfg.data[0];
        REG_PRIME:        rows <= cfg_rows;
        REG_STRIDE:       cols <= cfg_cols;
      endcase
    end
  end

  // Pipeline control.
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic acc;
  logic wr_en;

  assign en3          = !v3 || results.ready;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign coeffs.ready = en1;
  assign acc          = coeffs.valid && en1;
  assign wr_en        = v2 && en3;

  // Position in the tensor.
  logic [CW-1:0] col;
  rows_t         row;
  logic [CW-1:0] col_now;
  rows_t         row_now;
  logic [SW-1:0] col_inc;
  rows_t         row_inc;
  logic          wrap;
  logic          col_last;
  logic          row_last;

  always_comb begin
    wrap     = (SW'(col) >= cols) || (row >= rows);
    col_now  = wrap ? '0 : col;
    row_now  = wrap ? '0 : row;
    col_inc  = SW'(col_now) + SW'(1);
    row_inc  = row_now + rows_t'(1);
    col_last = col_inc >= cols;
    row_last = row_inc >= rows;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row_inc;
      end else begin
        col <= col_inc[CW-1:0];
        row <= row_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= acc;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  // Stage registers.
  coeff_t        x1, xs1, fd1;
  logic          ge1, r01, fh1;
  logic [CW-1:0] c1;
  coeff_t        xr2, s2;
  logic          r02, bad2, hit2;
  logic [CW-1:0] c2;
  coeff_t        y3;
  logic          bad3;
  coeff_t        wb_data;

  coeff_t        rd_data;
  coeff_t        wr_data;

  // Input reduction, first half.
  logic   ge0;
  mod_t   xdiff0;

  always_comb begin
    ge0    = {1'b0, coeffs.coeff_in} >= q;
    xdiff0 = {1'b0, coeffs.coeff_in} - q;
  end

  // Stage 1: finish the reduction and saturate the stored value.
  coeff_t qm1;
  coeff_t xr1;
  coeff_t s_raw1;
  coeff_t s1;

  always_comb begin
    qm1 = COEFF_W'(q - mod_t'(1));
    if (!ge1) begin
      xr1 = x1;
    end else if ({1'b0, xs1} >= q) begin
      xr1 = qm1;
    end else begin
      xr1 = xs1;
    end
    s_raw1 = fh1 ? fd1 : rd_data;
    s1     = ({1'b0, s_raw1} >= q) ? qm1 : s_raw1;
  end

  // Stage 2: add or subtract mod q, or pass a first-row value through.
  coeff_t           s_eff2;
  mod_t             sum2;
  logic [MOD_W:0]   sum_m2;
  mod_t             dif2;
  mod_t             alt2;
  coeff_t           fwd_y2;
  coeff_t           inv_y2;
  coeff_t           y2;

  always_comb begin
    s_eff2 = hit2 ? wb_data : s2;
    sum2   = {1'b0, xr2} + {1'b0, s_eff2};
    sum_m2 = {1'b0, sum2} - {1'b0, q};
    fwd_y2 = sum_m2[MOD_W] ? sum2[COEFF_W-1:0] : sum_m2[COEFF_W-1:0];
    dif2   = {1'b0, xr2} - {1'b0, s_eff2};
    alt2   = {1'b0, xr2} + q - {1'b0, s_eff2};
    inv_y2 = dif2[MOD_W-1] ? alt2[COEFF_W-1:0] : dif2[COEFF_W-1:0];
    if (r02) begin
      y2 = xr2;
    end else if (inv) begin
      y2 = inv_y2;
    end else begin
      y2 = fwd_y2;
    end
    wr_data = (r02 || inv) ? xr2 : y2;
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      x1  <= coeffs.coeff_in;
      ge1 <= ge0;
      xs1 <= xdiff0[COEFF_W-1:0];
      c1  <= col_now;
      r01 <= row_now == '0;
      fh1 <= wr_en && (c2 == col_now);
      fd1 <= wr_data;
    end
    if (en2 && v1) begin
      xr2  <= xr1;
      s2   <= s1;
      c2   <= c1;
      r02  <= r01;
      bad2 <= ge1;
      hit2 <= wr_en && (c2 == c1);
    end
    if (en3 && v2) begin
      y3   <= y2;
      bad3 <= bad2;
    end
    if (wr_en) begin
      wb_data <= wr_data;
    end
  end

  spsd_ram #(
    .WIDTH (COEFF_W),
    .DEPTH (MAX_STRIDE)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (c2),
    .wr_data (wr_data),
    .rd_en   (acc),
    .rd_addr (col_now),
    .rd_data (rd_data)
  );

  assign results.valid     = v3;
  assign results.coeff_out = y3;
  assign results.bad_input = bad3;

endmodule

`default_nettype wire

[hw/rtl/spsd_checker.sv]
// Port-level checks for the strided prefix sum / difference block.
// Bound to the top level; depends on spsd_pkg and the top level's ports.
`default_nettype none

module spsd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input spsd_pkg::coeff_t coeff_out,
  input logic            bad_input
);

  import spsd_pkg::*;

  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  // A reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coeff_out) && $stable(bad_input))
    else $error("stalled result changed");

  // An empty output register never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Every result belongs to a coefficient taken earlier, and at most three are in flight.
  a_no_extra: assert property (@(posedge clk) disable iff (rst) out_valid |-> pending != 3'd0)
    else $error("result without a pending coefficient");

  a_depth: assert property (@(posedge clk) disable iff (rst) pending <= 3'd3)
    else $error("more coefficients in flight than pipeline stages");

endmodule

bind strided_prefix_sum_difference spsd_checker u_spsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (coeffs.valid),
  .in_ready  (coeffs.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .coeff_out (results.coeff_out),
  .bad_input (results.bad_input)
);

`default_nettype wire
